// ----- hdl/smp_pkg.sv -----
package smp_pkg;

  // Fixed field widths of the item channels.
  localparam int unsigned ActionWidth   = 3;
  localparam int unsigned TargetWidth   = 13;
  localparam int unsigned DirReqWidth   = 8;
  localparam int unsigned DivReqWidth   = 8;
  localparam int unsigned PositionWidth = 16;
  localparam int unsigned ReplyWidth    = 4;

  // Action codes carried by an input item.
  typedef enum logic [ActionWidth-1:0] {
    ACT_TICK      = 3'd0,
    ACT_MOVE_TO   = 3'd1,
    ACT_SINGLE    = 3'd2,
    ACT_SET_DIR   = 3'd3,
    ACT_SET_DIV   = 3'd4,
    ACT_ZERO      = 3'd5
  } action_e;

  // Direction request encodings.
  localparam logic [DirReqWidth-1:0] DirReqBackward = 8'h01;
  localparam logic [DirReqWidth-1:0] DirReqForward  = 8'hFF;

  // Replies to a set_direction item.
  localparam logic [ReplyWidth-1:0] ReplyBackward = 4'd0;
  localparam logic [ReplyWidth-1:0] ReplyForward  = 4'd1;
  localparam logic [ReplyWidth-1:0] ReplyInvalid  = 4'd2;

  // Divider codes: the divider is 1 << code, the step size 8 >> code.
  typedef logic [1:0] div_code_t;
  localparam div_code_t DivCode1 = 2'd0;
  localparam div_code_t DivCode2 = 2'd1;
  localparam div_code_t DivCode4 = 2'd2;
  localparam div_code_t DivCode8 = 2'd3;

endpackage

// ----- hdl/smp_in_if.sv -----
interface smp_in_if;
  import smp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [ActionWidth-1:0]        action;
  logic [TargetWidth-1:0]        target_full_steps;
  logic signed [DirReqWidth-1:0] direction_request;
  logic [DivReqWidth-1:0]        divider_request;

  modport source (
    output valid, action, target_full_steps, direction_request, divider_request,
    input  ready
  );

  modport sink (
    input  valid, action, target_full_steps, direction_request, divider_request,
    output ready
  );

endinterface

// ----- hdl/smp_out_if.sv -----
interface smp_out_if;
  import smp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [PositionWidth-1:0] position;
  logic                     step_pin;
  logic                     dir_pin;
  logic                     ms1_pin;
  logic                     ms2_pin;
  logic                     ms3_pin;
  logic                     moving;
  logic [ReplyWidth-1:0]    reply;

  modport source (
    output valid, position, step_pin, dir_pin, ms1_pin, ms2_pin, ms3_pin, moving, reply,
    input  ready
  );

  modport sink (
    input  valid, position, step_pin, dir_pin, ms1_pin, ms2_pin, ms3_pin, moving, reply,
    output ready
  );

endinterface

// ----- hdl/stepper_microstep_positioner_core.sv -----
// The result of an item is valid in the cycle after it is accepted. Throughput: one item
// per cycle while the sink takes each result. The state update is a single add or subtract
// and a few compares in front of the result register, which decouples the two channels.
// Reset (asynchronous, active low) clears the position, target and move flag, selects
// divide by one with ms1 high, sets the direction pin high and empties the result register.
module stepper_microstep_positioner_core #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  smp_in_if.sink    in_chan,
  smp_out_if.source out_chan
);
  import smp_pkg::*;

  localparam int unsigned PW = POSITION_WIDTH;

  // Motor state.
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] target_q, target_d;
  logic          dir_neg_q, dir_neg_d;
  div_code_t     code_q, code_d;
  logic          move_q, move_d;
  logic          step_q, step_d;
  logic          dir_q, dir_d;
  logic          ms1_q, ms1_d;
  logic          ms2_q, ms2_d;

  // Result register.
  logic                     out_valid_q;
  logic [PositionWidth-1:0] out_pos_q;
  logic                     out_step_q;
  logic                     out_dir_q;
  logic                     out_ms1_q;
  logic                     out_ms2_q;
  logic                     out_move_q;
  logic [ReplyWidth-1:0]    out_reply_q;

  logic                  accept;
  logic [PW-1:0]         tgt_scaled;
  logic [PW-1:0]         remaining;
  div_code_t             move_code;
  div_code_t             step_code;
  logic                  do_step;
  logic [PW-1:0]         step_amount;
  logic [PW-1:0]         stepped_pos;
  div_code_t             req_code;
  logic [ReplyWidth-1:0] reply_d;

  // The input side is free whenever the result register is empty or being drained.
  assign in_chan.ready = !out_valid_q || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // Target in eighth-steps, wrapped to the position width.
  assign tgt_scaled = PW'({in_chan.target_full_steps, 3'b000});

  // Remaining distance of the active move, measured along the direction of travel.
  assign remaining = dir_neg_q ? (pos_q - target_q) : (target_q - pos_q);

  // Divider picked from the remaining distance: finer steps near the target.
  always_comb begin
    move_code = DivCode1;
    if (remaining < PW'(8)) move_code = DivCode2;
    if (remaining < PW'(4)) move_code = DivCode4;
    if (remaining < PW'(2)) move_code = DivCode8;
  end

  // Requested divider from a set_divider item; unknown values fall back to one.
  always_comb begin
    case (in_chan.divider_request)
      8'd2:    req_code = DivCode2;
      8'd4:    req_code = DivCode4;
      8'd8:    req_code = DivCode8;
      default: req_code = DivCode1;
    endcase
  end

  // One step moves the position by 8 >> code eighth-steps in the current direction.
  assign step_code   = move_q ? move_code : code_q;
  assign step_amount = PW'(4'd8 >> step_code);
  assign stepped_pos = dir_neg_q ? (pos_q - step_amount) : (pos_q + step_amount);

  // Next state for the accepted item.
  always_comb begin
    pos_d    = pos_q;
    target_d = target_q;
    dir_neg_d = dir_neg_q;
    code_d   = code_q;
    move_d   = move_q;
    step_d   = step_q;
    dir_d    = dir_q;
    ms1_d    = ms1_q;
    ms2_d    = ms2_q;
    reply_d  = '0;
    do_step  = 1'b0;

    if (move_q) begin
      // While a move runs only ticks count; they step and re-pick the divider.
      if (in_chan.action == ACT_TICK) begin
        code_d  = move_code;
        ms1_d   = move_code[0];
        ms2_d   = move_code[1];
        do_step = 1'b1;
        if (stepped_pos == target_q) begin
          move_d = 1'b0;
        end
      end
    end else begin
      case (in_chan.action)
        ACT_MOVE_TO: begin
          target_d = tgt_scaled;
          if (pos_q < tgt_scaled) begin
            dir_neg_d = 1'b0;
            dir_d     = 1'b0;
            move_d    = 1'b1;
          end else if (pos_q > tgt_scaled) begin
            dir_neg_d = 1'b1;
            dir_d     = 1'b1;
            move_d    = 1'b1;
          end
        end
        ACT_SINGLE: begin
          do_step = 1'b1;
        end
        ACT_SET_DIR: begin
          if (in_chan.direction_request == DirReqBackward) begin
            dir_neg_d = 1'b0;
            dir_d     = 1'b0;
            reply_d   = ReplyBackward;
          end else if (in_chan.direction_request == DirReqForward) begin
            dir_neg_d = 1'b1;
            dir_d     = 1'b1;
            reply_d   = ReplyForward;
          end else begin
            dir_neg_d = 1'b0;
            dir_d     = 1'b0;
            reply_d   = ReplyInvalid;
          end
        end
        ACT_SET_DIV: begin
          code_d  = req_code;
          ms1_d   = req_code[0];
          ms2_d   = req_code[1];
          reply_d = ReplyWidth'(4'd1 << req_code);
        end
        ACT_ZERO: begin
          pos_d = '0;
        end
        default: begin
        end
      endcase
    end

    if (do_step) begin
      step_d = !step_q;
      pos_d  = stepped_pos;
    end
  end

  // State registers update only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      target_q  <= '0;
      dir_neg_q <= 1'b0;
      code_q    <= DivCode1;
      move_q    <= 1'b0;
      step_q    <= 1'b0;
      dir_q     <= 1'b1;
      ms1_q     <= 1'b1;
      ms2_q     <= 1'b0;
    end else if (accept) begin
      pos_q     <= pos_d;
      target_q  <= target_d;
      dir_neg_q <= dir_neg_d;
      code_q    <= code_d;
      move_q    <= move_d;
      step_q    <= step_d;
      dir_q     <= dir_d;
      ms1_q     <= ms1_d;
      ms2_q     <= ms2_d;
    end
  end

  // Result valid flag: set by an accepted item, cleared when the sink takes the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload holds the state left by the item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_pos_q   <= PositionWidth'(pos_d);
      out_step_q  <= step_d;
      out_dir_q   <= dir_d;
      out_ms1_q   <= ms1_d;
      out_ms2_q   <= ms2_d;
      out_move_q  <= move_d;
      out_reply_q <= reply_d;
    end
  end

  assign out_chan.valid    = out_valid_q;
  assign out_chan.position = out_pos_q;
  assign out_chan.step_pin = out_step_q;
  assign out_chan.dir_pin  = out_dir_q;
  assign out_chan.ms1_pin  = out_ms1_q;
  assign out_chan.ms2_pin  = out_ms2_q;
  assign out_chan.ms3_pin  = 1'b0;
  assign out_chan.moving   = out_move_q;
  assign out_chan.reply    = out_reply_q;

  // A non-tick item during a move must leave the position alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && move_q && in_chan.action != ACT_TICK) |=> (pos_q == $past(pos_q)))
    else $error("position changed by an item ignored during a move");

  // A move_to to a different position while idle starts a move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !move_q && in_chan.action == ACT_MOVE_TO && tgt_scaled != pos_q) |=> move_q)
    else $error("move_to did not start a move");

  // A move is only in progress while the target is still ahead.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    move_q |-> (pos_q != target_q))
    else $error("move still active on the target");

  // During a move the direction pin agrees with the direction of travel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    move_q |-> (dir_q == dir_neg_q))
    else $error("direction pin disagrees with direction of travel");

  // Every accepted item leaves a result in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item produced no result");

endmodule

// ----- dv/stepper_microstep_positioner_core_tb.sv -----
module stepper_microstep_positioner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smp_pkg::*;

  // Action codes with no command behind them; the block must ignore them.
  localparam logic [ActionWidth-1:0] ActSpare6 = 3'd6;
  localparam logic [ActionWidth-1:0] ActSpare7 = 3'd7;

  localparam int RandomItems = 1500;
  localparam int StallLimit  = 2000;
  localparam int TailCycles  = 5;
  localparam int HoldCycles  = 80;
  localparam int MaxReports  = 30;
  localparam int MaxTarget   = 8191;

  // Pin levels and reply that one item leaves behind.
  typedef struct {
    logic [PositionWidth-1:0] position;
    logic                     step;
    logic                     dir;
    logic                     ms1;
    logic                     ms2;
    logic                     ms3;
    logic                     moving;
    logic [ReplyWidth-1:0]    reply;
  } pin_state_t;

  logic clk_i;
  logic rst_ni;

  smp_in_if  in_chan ();
  smp_out_if out_chan ();

  stepper_microstep_positioner_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Motor state as the block should hold it.
  logic [PositionWidth-1:0] motor_pos;
  logic [PositionWidth-1:0] motor_target;
  logic                     motor_negative;
  logic                     motor_moving;
  logic                     step_level;
  logic                     dir_level;
  logic                     ms1_level;
  logic                     ms2_level;
  div_code_t                step_code;

  pin_state_t expected_pins[$];
  int         items_sent;
  int         results_checked;
  int         moves_landed;
  int         mismatches;
  int         hold_request = 0;
  int         idle_cycles = 0;
  bit         steady;

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void reset_motor();
    motor_pos      = '0;
    motor_target   = '0;
    motor_negative = 1'b0;
    motor_moving   = 1'b0;
    step_level     = 1'b0;
    dir_level      = 1'b1;
    ms1_level      = 1'b1;
    ms2_level      = 1'b0;
    step_code      = DivCode1;
  endfunction

  function automatic void select_microstep(div_code_t code);
    step_code = code;
    ms1_level = code[0];
    ms2_level = code[1];
  endfunction

  function automatic void take_step();
    logic [PositionWidth-1:0] amount;
    amount     = PositionWidth'(8) >> step_code;
    step_level = ~step_level;
    if (motor_negative) begin
      motor_pos = motor_pos - amount;
    end else begin
      motor_pos = motor_pos + amount;
    end
  endfunction

  function automatic void set_direction(logic forward);
    dir_level      = forward;
    motor_negative = forward;
  endfunction

  // Applies one accepted item to the motor state and returns the pins it leaves.
  function automatic pin_state_t advance_positioner(logic [ActionWidth-1:0] act,
                                                    logic [TargetWidth-1:0] tgt,
                                                    logic [DirReqWidth-1:0] dreq,
                                                    logic [DivReqWidth-1:0] vreq);
    pin_state_t               pins;
    logic [PositionWidth-1:0] remaining;
    div_code_t                code;
    logic [ReplyWidth-1:0]    reply;
    reply = '0;
    if (motor_moving) begin
      // While a move runs only ticks count; the step shrinks near the target.
      if (act == ACT_TICK) begin
        remaining = motor_negative ? motor_pos - motor_target : motor_target - motor_pos;
        code = DivCode1;
        if (remaining < PositionWidth'(8)) code = DivCode2;
        if (remaining < PositionWidth'(4)) code = DivCode4;
        if (remaining < PositionWidth'(2)) code = DivCode8;
        select_microstep(code);
        take_step();
        if (motor_pos == motor_target) begin
          motor_moving = 1'b0;
          moves_landed++;
        end
      end
    end else begin
      case (act)
        ACT_MOVE_TO: begin
          motor_target = {tgt, 3'b000};
          if (motor_pos < motor_target) begin
            set_direction(1'b0);
            motor_moving = 1'b1;
          end else if (motor_pos > motor_target) begin
            set_direction(1'b1);
            motor_moving = 1'b1;
          end
        end
        ACT_SINGLE: begin
          take_step();
        end
        ACT_SET_DIR: begin
          if (dreq == DirReqBackward) begin
            set_direction(1'b0);
            reply = ReplyBackward;
          end else if (dreq == DirReqForward) begin
            set_direction(1'b1);
            reply = ReplyForward;
          end else begin
            set_direction(1'b0);
            reply = ReplyInvalid;
          end
        end
        ACT_SET_DIV: begin
          code = DivCode1;
          if (vreq == 8'd2) code = DivCode2;
          else if (vreq == 8'd4) code = DivCode4;
          else if (vreq == 8'd8) code = DivCode8;
          select_microstep(code);
          reply = 4'd1 << code;
        end
        ACT_ZERO: begin
          motor_pos = '0;
        end
        default: begin
        end
      endcase
    end
    pins.position = motor_pos;
    pins.step     = step_level;
    pins.dir      = dir_level;
    pins.ms1      = ms1_level;
    pins.ms2      = ms2_level;
    pins.ms3      = 1'b0;
    pins.moving   = motor_moving;
    pins.reply    = reply;
    return pins;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [ActionWidth-1:0] any_action();
    return ActionWidth'($urandom_range(7));
  endfunction

  function automatic logic [TargetWidth-1:0] any_target();
    return TargetWidth'($urandom);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom);
  endfunction

  // Target in full steps within a spread around the current position.
  function automatic logic [TargetWidth-1:0] near_target(int spread);
    int goal;
    goal = int'(motor_pos >> 3) + int'($urandom_range(2 * spread)) - spread;
    if (goal < 0) goal = 0;
    if (goal > MaxTarget) goal = MaxTarget;
    return TargetWidth'(goal);
  endfunction

  function automatic logic [DivReqWidth-1:0] pick_divider();
    case ($urandom_range(4))
      0: return 8'd1;
      1: return 8'd2;
      2: return 8'd4;
      3: return 8'd8;
      default: return DivReqWidth'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [DirReqWidth-1:0] pick_direction();
    case ($urandom_range(2))
      0: return DirReqBackward;
      1: return DirReqForward;
      default: return DirReqWidth'($urandom_range(255));
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MaxReports) begin
      $display("MISMATCH @%0t result %0d: %s", $realtime, results_checked, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  // Offers one item from a falling edge and returns at the falling edge after it
  // is taken. Valid stays high so that a following item can go back to back.
  task automatic send_item(input logic [ActionWidth-1:0] act,
                           input logic [TargetWidth-1:0] tgt,
                           input logic [DirReqWidth-1:0] dreq,
                           input logic [DivReqWidth-1:0] vreq);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_chan.valid             <= 1'b1;
    in_chan.action            <= act;
    in_chan.target_full_steps <= tgt;
    in_chan.direction_request <= dreq;
    in_chan.divider_request   <= vreq;
    @(posedge clk_i);
    while (!in_chan.ready) @(posedge clk_i);
    expected_pins.push_back(advance_positioner(act, tgt, dreq, vreq));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_all_results();
    in_chan.valid <= 1'b0;
    wait (expected_pins.size() == 0);
    @(negedge clk_i);
  endtask

  // Arms a move and ticks it home, with ignored commands mixed into the ticks.
  task automatic run_move(logic [TargetWidth-1:0] tgt);
    send_item(ACT_MOVE_TO, tgt, any_byte(), any_byte());
    while (motor_moving) begin
      if ($urandom_range(99) < 15) begin
        send_item(any_action(), any_target(), any_byte(), any_byte());
      end else begin
        send_item(ACT_TICK, any_target(), any_byte(), any_byte());
      end
    end
  endtask

  // Reset levels, idle tick and the unused action codes.
  task automatic test_idle_state();
    send_item(ACT_TICK, '0, '0, '0);
    send_item(ActSpare6, '1, '1, '1);
    send_item(ActSpare7, '0, '0, '0);
  endtask

  // Dividers 2, 8 and 4, illegal ones that fall back to one, and the step size at 2 and 8.
  task automatic test_divider_select();
    send_item(ACT_SET_DIV, '0, '0, 8'd2);
    send_item(ACT_SINGLE, '0, '0, '0);
    send_item(ACT_SET_DIV, '0, '0, 8'd8);
    send_item(ACT_SINGLE, '0, '0, '0);
    send_item(ACT_SET_DIV, '0, '0, 8'd0);
    send_item(ACT_SET_DIV, '0, '0, 8'hFF);
    send_item(ACT_SET_DIV, '0, '0, 8'd4);
  endtask

  // Both legal direction requests and invalid ones at the extremes.
  task automatic test_direction_select();
    send_item(ACT_SET_DIR, '0, DirReqBackward, '0);
    send_item(ACT_SET_DIR, '0, DirReqForward, '0);
    send_item(ACT_SET_DIR, '0, 8'h00, '0);
    send_item(ACT_SET_DIR, '0, 8'h80, '0);
  endtask

  // Wrap below zero, a short move onto the highest target with busy commands
  // in between, a target already reached, and a wrap above the top.
  task automatic test_wrap_and_landing();
    send_item(ACT_ZERO, '0, '0, '0);
    send_item(ACT_SET_DIR, '0, DirReqForward, '0);
    send_item(ACT_SET_DIV, '0, '0, 8'd8);
    send_item(ACT_SINGLE, '0, '0, '0);
    send_item(ACT_MOVE_TO, '1, '0, '0);
    send_item(ACT_TICK, '0, '0, '0);
    send_item(ACT_SINGLE, '0, '0, '0);
    send_item(ACT_MOVE_TO, '0, '0, '0);
    send_item(ACT_TICK, '0, '0, '0);
    send_item(ACT_TICK, '0, '0, '0);
    send_item(ACT_MOVE_TO, '1, '0, '0);
    send_item(ACT_SET_DIR, '0, DirReqBackward, '0);
    send_item(ACT_SET_DIV, '0, '0, 8'd1);
    send_item(ACT_SINGLE, '0, '0, '0);
    send_item(ACT_MOVE_TO, '0, '0, '0);
  endtask

  // Mostly complete moves near the current position after random setup, some
  // longer ones, and bursts of random items with targets near the current position.
  task automatic test_random_moves();
    int last;
    int roll;
    last = items_sent + RandomItems;
    while (items_sent < last) begin
      if ($urandom_range(99) < 15) steady = ~steady;
      roll = $urandom_range(99);
      if (roll < 25) begin
        repeat ($urandom_range(6, 1)) begin
          send_item(any_action(),
                    ($urandom_range(3) == 0) ? near_target(60) : near_target(4),
                    any_byte(), any_byte());
        end
      end else begin
        repeat ($urandom_range(3)) begin
          case ($urandom_range(3))
            0: send_item(ACT_SET_DIV, any_target(), any_byte(), pick_divider());
            1: send_item(ACT_SET_DIR, any_target(), pick_direction(), any_byte());
            2: send_item(ACT_SINGLE, any_target(), any_byte(), any_byte());
            default: send_item(ACT_ZERO, any_target(), any_byte(), any_byte());
          endcase
        end
        if (roll < 28) begin
          run_move(near_target(400));
        end else begin
          run_move(near_target(40));
        end
      end
      // A random item may have armed a move; finish it with plain ticks.
      while (motor_moving) send_item(ACT_TICK, any_target(), any_byte(), any_byte());
      if ($urandom_range(99) < 5) wait_all_results();
    end
    steady = 1'b0;
  endtask

  // The receiver holds off while items keep coming, so the block must stall.
  task automatic test_output_backpressure();
    steady = 1'b1;
    hold_request = HoldCycles;
    repeat (20) begin
      send_item(($urandom_range(1) == 0) ? ACT_SINGLE : ACT_SET_DIV, any_target(), any_byte(),
                pick_divider());
    end
    steady = 1'b0;
  endtask

  // The sender stops until every result is back, then starts again.
  task automatic test_sender_pause();
    repeat (3) begin
      repeat ($urandom_range(5, 1)) begin
        send_item(ACT_SINGLE, any_target(), any_byte(), any_byte());
      end
      wait_all_results();
    end
  endtask

  // Receiver readiness: random stalls, none in steady stretches, and a long
  // hold when a test asks for one.
  initial begin
    int stall;
    stall = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (stall == 0 && !steady) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        stall--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Each result taken is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    pin_state_t want;
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      if (expected_pins.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = expected_pins.pop_front();
        check_field("position", 32'(out_chan.position), 32'(want.position));
        check_field("step_pin", 32'(out_chan.step_pin), 32'(want.step));
        check_field("dir_pin", 32'(out_chan.dir_pin), 32'(want.dir));
        check_field("ms1_pin", 32'(out_chan.ms1_pin), 32'(want.ms1));
        check_field("ms2_pin", 32'(out_chan.ms2_pin), 32'(want.ms2));
        check_field("ms3_pin", 32'(out_chan.ms3_pin), 32'(want.ms3));
        check_field("moving", 32'(out_chan.moving), 32'(want.moving));
        check_field("reply", 32'(out_chan.reply), 32'(want.reply));
      end
      results_checked++;
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("timeout: no item moved for %0d cycles", StallLimit);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni                    = 1'b0;
    in_chan.valid             = 1'b0;
    in_chan.action            = ACT_TICK;
    in_chan.target_full_steps = '0;
    in_chan.direction_request = '0;
    in_chan.divider_request   = '0;
    items_sent      = 0;
    results_checked = 0;
    moves_landed    = 0;
    mismatches      = 0;
    steady          = 1'b0;
    reset_motor();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_idle_state();
    test_divider_select();
    test_direction_select();
    test_wrap_and_landing();
    test_random_moves();
    test_output_backpressure();
    test_sender_pause();

    wait_all_results();
    repeat (TailCycles) @(posedge clk_i);
    $display("run: %0d items sent, %0d results checked, %0d moves landed on target",
             items_sent, results_checked, moves_landed);
    $display("run: %0d field mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/smp_pkg.sv
hdl/smp_in_if.sv
hdl/smp_out_if.sv
hdl/stepper_microstep_positioner_core.sv
dv/stepper_microstep_positioner_core_tb.sv
